/* rtl/dep_pkg.sv */
// Package for the difference-equation PID step block.
// Holds the widths, fixed-point constants, register codes and the structs shared by the rtl.
// No dependencies.
package dep_pkg;

  localparam int unsigned SampleW   = 16;
  localparam int unsigned GainW     = 32;
  localparam int unsigned ErrW      = SampleW + 1;
  localparam int unsigned DriveW    = 32;
  localparam int unsigned DriveFrac = 16;
  localparam int unsigned ProdW     = GainW + ErrW;
  localparam int unsigned DrvFullW  = GainW + DriveW + 1;
  localparam int unsigned AccW      = ProdW + 2;
  localparam int unsigned OutW      = 23;
  localparam int unsigned CfgIdxW   = 3;

  localparam longint unsigned DriveLimit = 50000;
  localparam logic signed [AccW-1:0] DriveHiAcc = AccW'(DriveLimit << DriveFrac);

  // Division by 500 is done as a shift by two and a multiply by the rounded-up
  // reciprocal of 125, which is exact for every quotient below 2^30.
  localparam int unsigned QuotW   = DriveW - 2;
  localparam int unsigned RecipW  = 31;
  localparam int unsigned RecipSh = 37;
  localparam int unsigned ScaleW  = QuotW + RecipW;
  localparam logic [RecipW-1:0] Recip125 = RecipW'(64'd1099511628);

  typedef enum logic [CfgIdxW-1:0] {
    RegGainCur  = 3'd0,
    RegGainPrev = 3'd1,
    RegGainOld  = 3'd2,
    RegGainDrv  = 3'd3,
    RegTarget   = 3'd4
  } dep_reg_e;

  typedef struct packed {
    logic signed [GainW-1:0]   gain_cur;
    logic signed [GainW-1:0]   gain_prev;
    logic signed [GainW-1:0]   gain_old;
    logic signed [GainW-1:0]   gain_drv;
    logic signed [SampleW-1:0] target;
  } dep_cfg_t;

  typedef struct packed {
    logic signed [ProdW-1:0] cur;
    logic signed [ProdW-1:0] prev;
    logic signed [ProdW-1:0] old;
    logic signed [ProdW-1:0] drv;
  } dep_prod_t;

  typedef struct packed {
    logic [DriveW-1:0] drive;
    logic              upper;
    logic              lower;
  } dep_drive_t;

endpackage

/* rtl/dep_cfg.sv */
// Configuration register file: four signed gains and the setpoint.
// Depends on dep_pkg.
module dep_cfg
  import dep_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [GainW-1:0]   cfg_wdata_i,
  output dep_cfg_t           cfg_o
);

  dep_cfg_t cfg_q;
  dep_cfg_t cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (dep_reg_e'(cfg_idx_i))
        RegGainCur:  cfg_d.gain_cur  = cfg_wdata_i;
        RegGainPrev: cfg_d.gain_prev = cfg_wdata_i;
        RegGainOld:  cfg_d.gain_old  = cfg_wdata_i;
        RegGainDrv:  cfg_d.gain_drv  = cfg_wdata_i;
        RegTarget:   cfg_d.target    = cfg_wdata_i[SampleW-1:0];
        default:     cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* rtl/dep_prod.sv */
// Product stage: the three error terms and the floored drive feedback term.
// Depends on dep_pkg.
module dep_prod
  import dep_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  load_i,
  input  dep_cfg_t              cfg_i,
  input  logic signed [ErrW-1:0] err_i,
  input  logic signed [ErrW-1:0] err_last_i,
  input  logic signed [ErrW-1:0] err_older_i,
  input  logic [DriveW-1:0]     drive_older_i,
  output dep_prod_t             prod_o
);

  dep_prod_t                   prod_q;
  dep_prod_t                   prod_d;
  logic signed [DrvFullW-1:0]  drv_full;

  always_comb begin
    drv_full     = cfg_i.gain_drv * $signed({1'b0, drive_older_i});
    prod_d.cur   = cfg_i.gain_cur * err_i;
    prod_d.prev  = cfg_i.gain_prev * err_last_i;
    prod_d.old   = cfg_i.gain_old * err_older_i;
    // Dropping the low fraction bits of a two's complement value floors it.
    prod_d.drv   = drv_full[DriveFrac +: ProdW];
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;

endmodule

/* rtl/dep_clamp.sv */
// Accumulate stage: sums the terms, clamps to 0..50000 and keeps the drive history.
// Depends on dep_pkg.
module dep_clamp
  import dep_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  dep_prod_t         prod_i,
  output dep_drive_t        drive_o,
  output logic [DriveW-1:0] last_drive_o,
  output logic [DriveW-1:0] drive_before_o
);

  logic signed [AccW-1:0] acc;
  dep_drive_t             drive_d;
  dep_drive_t             drive_q;
  logic [DriveW-1:0]      last_drive_q;
  logic [DriveW-1:0]      drive_before_q;

  always_comb begin
    acc = AccW'(prod_i.cur) + AccW'(prod_i.prev) + AccW'(prod_i.old) - AccW'(prod_i.drv);
    drive_d.upper = 1'b0;
    drive_d.lower = 1'b0;
    if (acc > DriveHiAcc) begin
      drive_d.drive = DriveHiAcc[DriveW-1:0];
      drive_d.upper = 1'b1;
    end else if (acc < 0) begin
      drive_d.drive = '0;
      drive_d.lower = 1'b1;
    end else begin
      drive_d.drive = acc[DriveW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      drive_q <= drive_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_drive_q   <= '0;
      drive_before_q <= '0;
    end else if (load_i) begin
      last_drive_q   <= drive_d.drive;
      drive_before_q <= last_drive_q;
    end
  end

  assign drive_o        = drive_q;
  assign last_drive_o   = last_drive_q;
  assign drive_before_o = drive_before_q;

endmodule

/* rtl/dep_scale.sv */
// Output stage: scales the clamped drive by 0.002 into Q7.16 and holds the result beat.
// Depends on dep_pkg.
module dep_scale
  import dep_pkg::*;
(
  input  logic            clk_i,
  input  logic            load_i,
  input  dep_drive_t      drive_i,
  output logic [OutW-1:0] drive_scaled_o,
  output logic            hit_upper_limit_o,
  output logic            hit_lower_limit_o
);

  logic [ScaleW-1:0] scaled;
  logic [OutW-1:0]   scaled_q;
  logic              upper_q;
  logic              lower_q;

  assign scaled = ScaleW'(drive_i.drive[DriveW-1:2]) * ScaleW'(Recip125);

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      scaled_q <= scaled[RecipSh +: OutW];
      upper_q  <= drive_i.upper;
      lower_q  <= drive_i.lower;
    end
  end

  assign drive_scaled_o    = scaled_q;
  assign hit_upper_limit_o = upper_q;
  assign hit_lower_limit_o = lower_q;

endmodule

/* rtl/difference_equation_pid_step.sv */
// Discrete PID step in difference-equation form, four register stages deep.
// A sample beat moves through the input, product, accumulate and output registers in order.
// Throughput: one sample per cycle while out_stall_i is low; the drive fed back from two samples
// earlier leaves the accumulate stage just in time for the product stage of the sample after next.
// Reset clears the gains, setpoint, error and drive histories and all stage valids.
// Depends on dep_pkg, dep_cfg, dep_prod, dep_clamp and dep_scale.
module difference_equation_pid_step
  import dep_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [GainW-1:0]   cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [SampleW-1:0] sample_value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [OutW-1:0]    drive_scaled_o,
  output logic               hit_upper_limit_o,
  output logic               hit_lower_limit_o
);

  dep_cfg_t               cfg;
  dep_prod_t              prod;
  dep_drive_t             drive;
  logic [DriveW-1:0]      last_drive;
  logic [DriveW-1:0]      drive_before;
  logic [DriveW-1:0]      drive_older;

  logic signed [ErrW-1:0] err;
  logic signed [ErrW-1:0] last_err_q;
  logic signed [ErrW-1:0] err_before_q;
  logic signed [ErrW-1:0] s0_err_q;
  logic signed [ErrW-1:0] s0_last_q;
  logic signed [ErrW-1:0] s0_older_q;

  logic v0_q, v1_q, v2_q, v3_q;
  logic rdy0, rdy1, rdy2, rdy3;
  logic accept;

  assign rdy3   = !v3_q || !out_stall_i;
  assign rdy2   = !v2_q || rdy3;
  assign rdy1   = !v1_q || rdy2;
  assign rdy0   = !v0_q || rdy1;
  assign accept = in_valid_i && rdy0;

  assign in_stall_o  = !rdy0;
  assign out_valid_o = v3_q;

  assign err = ErrW'(cfg.target) - ErrW'($signed(sample_value_i));

  // While the previous sample still sits in the product stage it has not yet
  // shifted the drive history, so the drive from two samples back is the newest one.
  assign drive_older = v1_q ? last_drive : drive_before;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q         <= 1'b0;
      v1_q         <= 1'b0;
      v2_q         <= 1'b0;
      v3_q         <= 1'b0;
      last_err_q   <= '0;
      err_before_q <= '0;
    end else begin
      if (rdy0) begin
        v0_q <= in_valid_i;
      end
      if (rdy1) begin
        v1_q <= v0_q;
      end
      if (rdy2) begin
        v2_q <= v1_q;
      end
      if (rdy3) begin
        v3_q <= v2_q;
      end
      if (accept) begin
        last_err_q   <= err;
        err_before_q <= last_err_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s0_err_q   <= err;
      s0_last_q  <= last_err_q;
      s0_older_q <= err_before_q;
    end
  end

  dep_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  dep_prod u_prod (
    .clk_i         (clk_i),
    .load_i        (v0_q && rdy1),
    .cfg_i         (cfg),
    .err_i         (s0_err_q),
    .err_last_i    (s0_last_q),
    .err_older_i   (s0_older_q),
    .drive_older_i (drive_older),
    .prod_o        (prod)
  );

  dep_clamp u_clamp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .load_i         (v1_q && rdy2),
    .prod_i         (prod),
    .drive_o        (drive),
    .last_drive_o   (last_drive),
    .drive_before_o (drive_before)
  );

  dep_scale u_scale (
    .clk_i             (clk_i),
    .load_i            (v2_q && rdy3),
    .drive_i           (drive),
    .drive_scaled_o    (drive_scaled_o),
    .hit_upper_limit_o (hit_upper_limit_o),
    .hit_lower_limit_o (hit_lower_limit_o)
  );

endmodule

/* verif/difference_equation_pid_step_test.sv */
`timescale 1ns / 1ps
// Self-checking testbench for difference_equation_pid_step, a fixed-point PID update.
// A queue-fed driver and a clocked monitor check every drive beat against a local predictor.
// Depends on dep_pkg and the difference_equation_pid_step rtl.
module difference_equation_pid_step_test;
  import dep_pkg::*;

  localparam int     ResetCycles = 12;
  localparam int     WatchdogMax = 3000;
  localparam int     HoldAt      = 200;
  localparam int     HoldCycles  = 300;
  localparam int     DrainCycles = 20;
  localparam int     RunItems    = 165;
  localparam longint DriveCeil   = longint'(DriveLimit) << DriveFrac;
  localparam longint ScaleDiv    = 500;

  typedef struct packed {
    logic [OutW-1:0] drive_scaled;
    logic            upper;
    logic            lower;
  } drive_beat_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [GainW-1:0]   cfg_wdata_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [SampleW-1:0] sample_value_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [OutW-1:0]    drive_scaled_o;
  logic               hit_upper_limit_o;
  logic               hit_lower_limit_o;

  logic signed [GainW-1:0]   k_now = '0;
  logic signed [GainW-1:0]   k_prev = '0;
  logic signed [GainW-1:0]   k_old = '0;
  logic signed [GainW-1:0]   k_fb = '0;
  logic signed [SampleW-1:0] setpoint = '0;
  logic signed [ErrW-1:0]    err_last = '0;
  logic signed [ErrW-1:0]    err_old = '0;
  logic [DriveW-1:0]         drv_last = '0;
  logic [DriveW-1:0]         drv_old = '0;

  logic [SampleW-1:0] sample_q[$];
  drive_beat_t        drive_expect_q[$];
  int                 issued_count = 0;
  int                 accepted_count = 0;
  int                 fail_count = 0;
  int                 quiet_cycles = 0;
  int                 send_idle_pct = 28;
  int                 recv_idle_pct = 62;
  int                 hold_left = 0;
  bit                 hold_done = 1'b0;
  logic               took_sample = 1'b0;

  difference_equation_pid_step uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .sample_value_i   (sample_value_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .drive_scaled_o   (drive_scaled_o),
    .hit_upper_limit_o(hit_upper_limit_o),
    .hit_lower_limit_o(hit_lower_limit_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic drive_beat_t predict_drive(input logic [SampleW-1:0] sample);
    logic signed [ErrW-1:0] err;
    longint                 fb_term;
    longint                 acc;
    longint unsigned        drive;
    drive_beat_t            beat;
    err = $signed({setpoint[SampleW-1], setpoint}) - $signed({sample[SampleW-1], sample});
    fb_term = longint'(k_fb) * longint'({32'd0, drv_old});
    acc = longint'(k_now) * longint'(err) + longint'(k_prev) * longint'(err_last)
        + longint'(k_old) * longint'(err_old) - (fb_term >>> DriveFrac);
    beat.upper = acc > DriveCeil;
    beat.lower = acc < 0;
    if (beat.upper) begin
      acc = DriveCeil;
    end
    if (beat.lower) begin
      acc = 0;
    end
    drive = longint'(acc);
    beat.drive_scaled = OutW'(drive / ScaleDiv);
    err_old = err_last;
    err_last = err;
    drv_old = drv_last;
    drv_last = drive[DriveW-1:0];
    return beat;
  endfunction

  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || took_sample)) begin
      if (sample_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid_i <= 1'b1;
        sample_value_i <= sample_q.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!hold_done && accepted_count >= HoldAt) begin
      hold_done <= 1'b1;
      hold_left <= HoldCycles;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin : scoreboard
    drive_beat_t want;
    took_sample <= in_valid_i && !in_stall_o;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (drive_expect_q.size() == 0) begin
          $error("drive beat with no expectation waiting");
          fail_count++;
        end else begin
          want = drive_expect_q.pop_front();
          if (drive_scaled_o !== want.drive_scaled) begin
            $error("drive_scaled: expected %0d, actual %0d", want.drive_scaled, drive_scaled_o);
            fail_count++;
          end
          if (hit_upper_limit_o !== want.upper) begin
            $error("hit_upper_limit: expected %0d, actual %0d", want.upper, hit_upper_limit_o);
            fail_count++;
          end
          if (hit_lower_limit_o !== want.lower) begin
            $error("hit_lower_limit: expected %0d, actual %0d", want.lower, hit_lower_limit_o);
            fail_count++;
          end
        end
      end
      if (in_valid_i && !in_stall_o) begin
        drive_expect_q.push_back(predict_drive(sample_value_i));
        accepted_count++;
      end
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WatchdogMax) begin
        $display("difference_equation_pid_step_test NOT OK");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [GainW-1:0] data);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    case (idx)
      RegGainCur:  k_now = data;
      RegGainPrev: k_prev = data;
      RegGainOld:  k_old = data;
      RegGainDrv:  k_fb = data;
      RegTarget:   setpoint = data[SampleW-1:0];
      default: ;
    endcase
  endtask

  task automatic set_gains(input logic [GainW-1:0] g_now, input logic [GainW-1:0] g_prev,
                           input logic [GainW-1:0] g_old, input logic [GainW-1:0] g_fb,
                           input logic [GainW-1:0] tgt_word);
    logic [CfgIdxW-1:0] spare_idx;
    spare_idx = CfgIdxW'($urandom_range(2 ** CfgIdxW - 1, int'(RegTarget) + 1));
    write_reg(RegGainCur, g_now);
    write_reg(RegGainPrev, g_prev);
    write_reg(spare_idx, $urandom());
    write_reg(RegGainOld, g_old);
    write_reg(RegGainDrv, g_fb);
    write_reg(RegTarget, tgt_word);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic queue_sample(input logic [SampleW-1:0] s);
    sample_q.push_back(s);
    issued_count++;
  endtask

  task automatic wait_idle();
    while (accepted_count != issued_count || drive_expect_q.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  function automatic logic [GainW-1:0] pick_gain(input int kind, input int span);
    case (kind)
      0: return GainW'(int'($urandom_range(2 * span)) - span);
      1: return $urandom();
      default: return ($urandom_range(1) != 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
    endcase
  endfunction

  function automatic logic [SampleW-1:0] pick_sample();
    int v;
    if ($urandom_range(99) < 70) begin
      v = int'(setpoint) + int'($urandom_range(4000)) - 2000;
      if (v > 32767) begin
        v = 32767;
      end
      if (v < -32768) begin
        v = -32768;
      end
      return SampleW'(v);
    end
    return SampleW'($urandom());
  endfunction

  task automatic random_setting(input int kind);
    logic [GainW-1:0]   junk;
    logic [SampleW-1:0] tgt;
    junk = $urandom();
    if (kind == 2) begin
      tgt = ($urandom_range(1) != 0) ? 16'h7FFF : 16'h8000;
    end else begin
      tgt = SampleW'($urandom());
    end
    set_gains(pick_gain(kind, 32'h4_0000), pick_gain(kind, 32'h4_0000),
              pick_gain(kind, 32'h4_0000), pick_gain(kind, 32'h8000),
              {junk[GainW-1:SampleW], tgt});
  endtask

  initial begin
    repeat (ResetCycles) @(negedge clk_i);
    rst_ni <= 1'b1;

    set_gains(32'h0002_0000, 32'h0, 32'h0, 32'hFFFF_FFFF, 32'hABCD_0000);
    queue_sample(16'(-25000));
    queue_sample(16'(-25001));
    queue_sample(16'd0);
    queue_sample(16'd1);
    queue_sample(16'h8000);
    queue_sample(16'h7FFF);
    queue_sample(16'd12345);
    queue_sample(16'hFFFF);
    wait_idle();

    set_gains(32'h0000_8000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_0000, 32'hFFFF_7FFF);
    queue_sample(16'h8000);
    queue_sample(16'h7FFF);
    queue_sample(16'h8000);
    queue_sample(16'd0);
    wait_idle();

    set_gains(32'h8000_0000, 32'h0, 32'h0001_0000, 32'h7FFF_FFFF, 32'h0000_8000);
    queue_sample(16'h7FFF);
    queue_sample(16'h8000);
    queue_sample(16'd100);
    queue_sample(16'(-100));
    wait_idle();

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 28 : (phase == 1) ? 62 : 0;
      recv_idle_pct = (phase == 0) ? 62 : (phase == 1) ? 28 : 0;
      for (int setting = 0; setting < 4; setting++) begin
        random_setting((setting == 3) ? 2 : (setting == 2) ? 1 : 0);
        for (int n = 0; n < RunItems; n++) begin
          queue_sample(pick_sample());
        end
        wait_idle();
      end
    end

    repeat (DrainCycles) @(negedge clk_i);
    if (drive_expect_q.size() != 0) begin
      $error("%0d drive beats still expected", drive_expect_q.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("difference_equation_pid_step_test OK");
    end else begin
      $display("difference_equation_pid_step_test NOT OK");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/dep_pkg.sv
rtl/dep_cfg.sv
rtl/dep_prod.sv
rtl/dep_clamp.sv
rtl/dep_scale.sv
rtl/difference_equation_pid_step.sv
verif/difference_equation_pid_step_test.sv
